FILE: src/jhtd_pkg.sv
package jhtd_pkg;

   localparam int COUNT_BYTES   = 16;
   localparam int MAX_CODE_LEN  = 16;
   localparam int MAX_SYMBOLS   = 256;
   localparam int CLASS_BIT_POS = 4;
   localparam int SYM_AW        = $clog2(MAX_SYMBOLS);
   localparam int SYM_DW        = 8;

   localparam logic [16:0] BROKEN_CODE = 17'h1FFFF;
   localparam logic [8:0]  LOAD_MAX    = 9'd511;

   typedef enum logic [2:0] {
      ST_NEED_BIT    = 3'd0,
      ST_SYMBOL      = 3'd1,
      ST_INVALID_BIT = 3'd2,
      ST_BYTE_TAKEN  = 3'd3,
      ST_TABLE_READY = 3'd4,
      ST_TABLE_BAD   = 3'd5
   } status_type;

endpackage

FILE: src/jpeg_huffman_table_decoder.sv
// channel  direction  payload                                         handshake
// req      in         cmd, table_byte, last_table_byte, code_bit      req_valid / req_stall
// rsp      out        status, symbol, code_length, table_class        rsp_valid / rsp_stall
//
// one word per cycle on both sides while neither side stalls; every word gives
// exactly one result word; the walk and table state update at accept, the symbol
// store read lands in the read stage, then the output register takes the result
// reset (synchronous) clears the control state and the per-length counts; the
// symbol store needs no clearing pass, so the block takes words right away
// req_stall rises only while both the read stage and the output register are full
module jpeg_huffman_table_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [7:0]            req_table_byte,
   input  logic                  req_last_table_byte,
   input  logic                  req_code_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output jhtd_pkg::status_type  rsp_status,
   output logic [7:0]            rsp_symbol,
   output logic [4:0]            rsp_code_length,
   output logic                  rsp_table_class
);

   import jhtd_pkg::*;

   // table state
   logic        class_ff, class_in;
   logic [8:0]  load_idx_ff, load_idx_in;
   logic [8:0]  sym_exp_ff, sym_exp_in;
   logic [16:0] next_code_ff, next_code_in;
   logic [16:0] first_code_ff [COUNT_BYTES];
   logic [16:0] first_code_in [COUNT_BYTES];
   logic [7:0]  count_ff [COUNT_BYTES];
   logic [7:0]  count_in [COUNT_BYTES];
   logic [8:0]  base_ff [COUNT_BYTES];
   logic [8:0]  base_in [COUNT_BYTES];
   logic [4:0]  deep_len_ff, deep_len_in;
   logic [15:0] deep_last_ff, deep_last_in;
   logic [15:0] cur_code_ff, cur_code_in;
   logic [4:0]  cur_len_ff, cur_len_in;
   logic        ready_ff, ready_in;

   // read stage and output register
   logic        s1_valid_ff, s1_valid_in;
   status_type  s1_status_ff, s1_status_in;
   logic [4:0]  s1_len_ff, s1_len_in;
   logic        s1_class_ff, s1_class_in;
   logic        s1_ram_ff, s1_ram_in;
   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [7:0]  rsp_symbol_ff;
   logic [4:0]  rsp_len_ff;
   logic        rsp_class_ff;

   logic        out_adv, s1_adv, accept;

   // symbol store port
   logic              wr_en, rd_en;
   logic [SYM_AW-1:0] wr_addr, rd_addr;
   logic [SYM_DW-1:0] rd_data;

   // load path
   logic [4:0]  ld_len;
   logic [3:0]  ld_li;
   logic [9:0]  ld_sum;
   logic [17:0] ld_nc;
   logic [17:0] ld_limit;
   logic [8:0]  ld_inc;
   logic [8:0]  ld_si;
   logic        ld_bad;

   // decode path
   logic [4:0]  dec_len;
   logic [3:0]  dec_li;
   logic [15:0] dec_code;
   logic [17:0] dec_diff;
   logic        dec_hit;
   logic [9:0]  dec_idx;
   logic [3:0]  dec_shift;
   logic [15:0] dec_top;
   logic        dec_deep;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = !s1_valid_ff || out_adv;
   assign req_stall = s1_valid_ff && !out_adv;
   assign accept    = req_valid && !req_stall;

   assign ld_len   = load_idx_ff[4:0];
   assign ld_li    = 4'(ld_len - 5'd1);
   assign ld_sum   = {1'b0, sym_exp_ff} + {2'b0, req_table_byte};
   assign ld_nc    = {1'b0, next_code_ff} + {10'b0, req_table_byte};
   assign ld_limit = 18'd1 << ld_len;
   assign ld_inc   = (load_idx_ff != LOAD_MAX) ? load_idx_ff + 9'd1 : load_idx_ff;
   assign ld_si    = load_idx_ff - 9'(COUNT_BYTES + 1);

   assign dec_len   = cur_len_ff + 5'd1;
   assign dec_li    = 4'(dec_len - 5'd1);
   assign dec_code  = {cur_code_ff[14:0], req_code_bit};
   assign dec_diff  = {2'b0, dec_code} - {1'b0, first_code_ff[dec_li]};
   assign dec_hit   = !dec_diff[17] && (dec_diff[16:0] < {9'b0, count_ff[dec_li]});
   assign dec_idx   = {1'b0, base_ff[dec_li]} + {2'b0, dec_diff[7:0]};
   assign dec_shift = 4'(deep_len_ff - dec_len);
   assign dec_top   = deep_last_ff >> dec_shift;
   assign dec_deep  = (dec_len > deep_len_ff) || (dec_len > 5'(MAX_CODE_LEN));

   always_comb begin
      class_in     = class_ff;
      load_idx_in  = load_idx_ff;
      sym_exp_in   = sym_exp_ff;
      next_code_in = next_code_ff;
      deep_len_in  = deep_len_ff;
      deep_last_in = deep_last_ff;
      cur_code_in  = cur_code_ff;
      cur_len_in   = cur_len_ff;
      ready_in     = ready_ff;
      for (int i = 0; i < COUNT_BYTES; i++) begin
         first_code_in[i] = first_code_ff[i];
         count_in[i]      = count_ff[i];
         base_in[i]       = base_ff[i];
      end
      wr_en        = 1'b0;
      wr_addr      = ld_si[SYM_AW-1:0];
      rd_en        = 1'b0;
      rd_addr      = dec_idx[SYM_AW-1:0];
      ld_bad       = 1'b0;
      s1_status_in = ST_INVALID_BIT;
      s1_len_in    = 5'd0;
      s1_ram_in    = 1'b0;

      if (accept && !req_cmd) begin
         if (load_idx_ff == 9'd0) begin
            class_in     = req_table_byte[CLASS_BIT_POS];
            sym_exp_in   = 9'd0;
            next_code_in = 17'd0;
            deep_len_in  = 5'd0;
            deep_last_in = 16'd0;
            ready_in     = 1'b0;
            for (int i = 0; i < COUNT_BYTES; i++) begin
               count_in[i] = 8'd0;
            end
         end else if (load_idx_ff <= 9'(COUNT_BYTES)) begin
            count_in[ld_li] = req_table_byte;
            base_in[ld_li]  = sym_exp_ff;
            sym_exp_in      = ld_sum[9] ? LOAD_MAX : ld_sum[8:0];
            if (next_code_ff != BROKEN_CODE) begin
               if (ld_len > 5'(MAX_CODE_LEN)) begin
                  if (req_table_byte != 8'd0) begin
                     next_code_in = BROKEN_CODE;
                  end
               end else begin
                  first_code_in[ld_li] = next_code_ff;
                  if (req_table_byte != 8'd0) begin
                     deep_len_in  = ld_len;
                     deep_last_in = ld_nc[15:0] - 16'd1;
                  end
                  if (ld_nc > ld_limit) begin
                     next_code_in = BROKEN_CODE;
                  end else if (ld_len < 5'd16) begin
                     next_code_in = {ld_nc[15:0], 1'b0};
                  end else begin
                     next_code_in = ld_nc[16:0];
                  end
               end
            end
         end else begin
            // symbol bytes past the counted ones are dropped
            wr_en = (ld_si < sym_exp_ff) && ({1'b0, ld_si} < 10'(MAX_SYMBOLS));
         end
         load_idx_in  = ld_inc;
         cur_code_in  = 16'd0;
         cur_len_in   = 5'd0;
         s1_status_in = ST_BYTE_TAKEN;
         if (req_last_table_byte) begin
            ld_bad = ({1'b0, ld_inc} < 10'(COUNT_BYTES + 1) + {1'b0, sym_exp_in})
                     || ({1'b0, sym_exp_in} > 10'(MAX_SYMBOLS))
                     || (next_code_in == BROKEN_CODE);
            load_idx_in  = 9'd0;
            ready_in     = !ld_bad;
            s1_status_in = ld_bad ? ST_TABLE_BAD : ST_TABLE_READY;
         end
      end else if (accept && ready_ff) begin
         if (dec_deep) begin
            cur_code_in  = 16'd0;
            cur_len_in   = 5'd0;
            s1_status_in = ST_INVALID_BIT;
         end else if (dec_hit) begin
            cur_code_in  = 16'd0;
            cur_len_in   = 5'd0;
            s1_status_in = ST_SYMBOL;
            s1_len_in    = dec_len;
            s1_ram_in    = dec_idx < 10'(MAX_SYMBOLS);
            rd_en        = 1'b1;
         end else if (dec_code > dec_top) begin
            cur_code_in  = 16'd0;
            cur_len_in   = 5'd0;
            s1_status_in = ST_INVALID_BIT;
         end else begin
            cur_code_in  = dec_code;
            cur_len_in   = dec_len;
            s1_status_in = ST_NEED_BIT;
         end
      end
      s1_class_in = class_in;
      s1_valid_in = s1_adv ? accept : s1_valid_ff;
   end

   jhtd_ram #(
      .WIDTH (SYM_DW),
      .DEPTH (MAX_SYMBOLS)
   ) u_symbol_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_table_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff     <= 1'b0;
         load_idx_ff  <= 9'd0;
         sym_exp_ff   <= 9'd0;
         next_code_ff <= 17'd0;
         deep_len_ff  <= 5'd0;
         deep_last_ff <= 16'd0;
         cur_code_ff  <= 16'd0;
         cur_len_ff   <= 5'd0;
         ready_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < COUNT_BYTES; i++) begin
            count_ff[i] <= 8'd0;
         end
      end else begin
         class_ff     <= class_in;
         load_idx_ff  <= load_idx_in;
         sym_exp_ff   <= sym_exp_in;
         next_code_ff <= next_code_in;
         deep_len_ff  <= deep_len_in;
         deep_last_ff <= deep_last_in;
         cur_code_ff  <= cur_code_in;
         cur_len_ff   <= cur_len_in;
         ready_ff     <= ready_in;
         s1_valid_ff  <= s1_valid_in;
         if (out_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         for (int i = 0; i < COUNT_BYTES; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < COUNT_BYTES; i++) begin
         first_code_ff[i] <= first_code_in[i];
         base_ff[i]       <= base_in[i];
      end
      if (s1_adv) begin
         s1_status_ff <= s1_status_in;
         s1_len_ff    <= s1_len_in;
         s1_class_ff  <= s1_class_in;
         s1_ram_ff    <= s1_ram_in;
      end
      if (out_adv) begin
         rsp_status_ff <= s1_status_ff;
         rsp_symbol_ff <= s1_ram_ff ? rd_data : 8'd0;
         rsp_len_ff    <= s1_len_ff;
         rsp_class_ff  <= s1_class_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_code_length = rsp_len_ff;
   assign rsp_table_class = rsp_class_ff;

`ifndef SYNTHESIS
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free stage");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff <= deep_len_ff)
      else $error("walk deeper than the longest code");

   a_ready_idle_load: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (load_idx_ff == 9'd0))
      else $error("table ready in the middle of a load");

   a_ram_only_symbol: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ram_ff) |-> (s1_status_ff == ST_SYMBOL))
      else $error("store read for a word that is not a symbol");

   a_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_SYMBOL)) |->
         ((rsp_symbol_ff == 8'd0) && (rsp_len_ff == 5'd0)))
      else $error("symbol fields set on a non-symbol word");
`endif

endmodule

FILE: src/jhtd_ram.sv
module jhtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
